// ===== src/mvat_pkg.sv =====
// ---------------------------------------------------------------------------
// Masked vertex affine transform: shared package
// Payload types, register map and arithmetic widths of the vertex transform.
// ---------------------------------------------------------------------------
package mvat_pkg;

    // Field widths of one vertex and of its selection bits.
    localparam int COORD_W = 32;
    localparam int SEL_W   = 32;

    // Configuration port: 64-bit data, registers on 8-byte boundaries.
    localparam int CFG_DW  = 64;
    localparam int ADDR_W  = 6;
    localparam int IDX_LSB = 3;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SEL_MASK = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRANS_X  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TRANS_Y  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANS_Z  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROT_QUAT = 3'd5;

    localparam int MASK_W  = 32;
    localparam int TRANS_W = 32;
    localparam int SCALE_W = 24;
    localparam int QUAT_W  = 64;
    localparam int QC_W    = 16;

    localparam logic [MASK_W-1:0]  RST_SEL_MASK = '1;
    localparam logic [SCALE_W-1:0] RST_SCALE    = 24'd65536;
    localparam logic [QUAT_W-1:0]  RST_ROT_QUAT = 64'd16384;

    // Datapath widths. Rotation entries are Q6.28, products of two
    // quaternion components are Q4.28 before doubling.
    localparam int QP_W    = 2 * QC_W;
    localparam int ROT_W   = 34;
    localparam int ROT_ONE_SH = 28;
    localparam int RS_W    = ROT_W + SCALE_W;
    localparam int RS_LO   = RS_W / 2;
    localparam int RS_HI   = RS_W - RS_LO;
    localparam int PL_W    = RS_LO + 1 + COORD_W;
    localparam int PH_W    = RS_HI + COORD_W;
    localparam int FRAC_SH = 44;
    localparam int ACC_W   = COORD_W + 61;
    localparam int RND_W   = ACC_W - FRAC_SH;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic        [SEL_W-1:0]   sel_bits;
    } t_vtx_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      moved;
        logic                      clipped;
    } t_vtx_out;

endpackage

// ===== src/masked_vertex_affine_transform.sv =====
// ---------------------------------------------------------------------------
// Masked vertex affine transform
// Rotates (unit quaternion), scales and translates selected mesh vertices.
// ---------------------------------------------------------------------------
// Usage:
// A vertex is handed over with start; busy is always low, so a vertex can be
// given in every clock cycle and each such cycle is one transfer. The block is
// an eight-stage pipeline that holds up to eight vertices at once. The result
// of a vertex appears on o_res, registered, with o_done high for exactly one
// cycle. Results leave in the order vertices arrived. Throughput is one vertex
// per cycle; it is set by the multiplier stages, which each start a new vertex
// in every cycle. A vertex whose selection bits share no bit with the
// selection mask passes through unchanged with moved and clipped low.
// Otherwise the result is R(q) * (s * v) + t, rounded once to Q16.16 and
// saturated. The receiver cannot stall, so the pipeline never holds.
// The configuration registers sit on an APB-style port at byte address 8*i;
// the user writes them only while no vertex is in flight, which the block
// itself does not enforce. Reset empties the pipeline and loads the identity
// transform with an all-ones mask.
// ---------------------------------------------------------------------------
module masked_vertex_affine_transform (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Vertex input channel.
    input  logic                            start,
    output logic                            busy,
    input  mvat_pkg::t_vtx_in               i_vtx,
    // Result channel.
    output logic                            o_done,
    output mvat_pkg::t_vtx_out              o_res,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mvat_pkg::ADDR_W-1:0]     paddr,
    input  logic [mvat_pkg::CFG_DW-1:0]     pwdata,
    output logic [mvat_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int COORD_W = mvat_pkg::COORD_W;
    localparam int ROT_W   = mvat_pkg::ROT_W;
    localparam int RS_W    = mvat_pkg::RS_W;
    localparam int RS_LO   = mvat_pkg::RS_LO;
    localparam int PL_W    = mvat_pkg::PL_W;
    localparam int PH_W    = mvat_pkg::PH_W;
    localparam int ACC_W   = mvat_pkg::ACC_W;
    localparam int RND_W   = mvat_pkg::RND_W;
    localparam int FRAC_SH = mvat_pkg::FRAC_SH;
    localparam int QC_W    = mvat_pkg::QC_W;
    localparam int QP_W    = mvat_pkg::QP_W;

    localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1) << mvat_pkg::ROT_ONE_SH;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_SH - 1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mvat_pkg::MASK_W-1:0]         r_sel_mask;
    logic signed [mvat_pkg::TRANS_W-1:0] r_trans [3];
    logic [mvat_pkg::SCALE_W-1:0]        r_scale;
    logic [mvat_pkg::QUAT_W-1:0]         r_quat;

    logic                                cfg_wr;
    logic [mvat_pkg::IDX_W-1:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[mvat_pkg::IDX_LSB +: mvat_pkg::IDX_W];

    // The address bits below the register index are not decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_mask <= mvat_pkg::RST_SEL_MASK;
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
            r_scale    <= mvat_pkg::RST_SCALE;
            r_quat     <= mvat_pkg::RST_ROT_QUAT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mvat_pkg::REG_SEL_MASK: r_sel_mask <= pwdata[mvat_pkg::MASK_W-1:0];
                mvat_pkg::REG_TRANS_X:  r_trans[0] <= pwdata[mvat_pkg::TRANS_W-1:0];
                mvat_pkg::REG_TRANS_Y:  r_trans[1] <= pwdata[mvat_pkg::TRANS_W-1:0];
                mvat_pkg::REG_TRANS_Z:  r_trans[2] <= pwdata[mvat_pkg::TRANS_W-1:0];
                mvat_pkg::REG_SCALE:    r_scale    <= pwdata[mvat_pkg::SCALE_W-1:0];
                mvat_pkg::REG_ROT_QUAT: r_quat     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mvat_pkg::REG_SEL_MASK: prdata = mvat_pkg::CFG_DW'(r_sel_mask);
            mvat_pkg::REG_TRANS_X:  prdata = mvat_pkg::CFG_DW'(unsigned'(r_trans[0]));
            mvat_pkg::REG_TRANS_Y:  prdata = mvat_pkg::CFG_DW'(unsigned'(r_trans[1]));
            mvat_pkg::REG_TRANS_Z:  prdata = mvat_pkg::CFG_DW'(unsigned'(r_trans[2]));
            mvat_pkg::REG_SCALE:    prdata = mvat_pkg::CFG_DW'(r_scale);
            mvat_pkg::REG_ROT_QUAT: prdata = r_quat;
            default:                prdata = '0;
        endcase
    end

    // The pipeline never holds, so a vertex is taken in every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the vertex and the configuration it sees, and form
    // the nine pairwise products of the quaternion components.
    // ------------------------------------------------------------------
    logic signed [QC_W-1:0] q_w, q_x, q_y, q_z;

    assign q_w = r_quat[0*QC_W +: QC_W];
    assign q_x = r_quat[1*QC_W +: QC_W];
    assign q_y = r_quat[2*QC_W +: QC_W];
    assign q_z = r_quat[3*QC_W +: QC_W];

    logic                                r_s1_vld;
    logic                                r_s1_hit;
    logic signed [COORD_W-1:0]           r_s1_pos [3];
    logic signed [mvat_pkg::TRANS_W-1:0] r_s1_trans [3];
    logic [mvat_pkg::SCALE_W-1:0]        r_s1_scale;
    logic signed [QP_W-1:0]              r_s1_xx, r_s1_yy, r_s1_zz;
    logic signed [QP_W-1:0]              r_s1_xy, r_s1_xz, r_s1_yz;
    logic signed [QP_W-1:0]              r_s1_wx, r_s1_wy, r_s1_wz;

    always_ff @(posedge i_clk) begin
        r_s1_pos[0] <= i_vtx.pos_x;
        r_s1_pos[1] <= i_vtx.pos_y;
        r_s1_pos[2] <= i_vtx.pos_z;
        r_s1_hit    <= |(i_vtx.sel_bits & r_sel_mask[mvat_pkg::SEL_W-1:0]);
        r_s1_trans  <= r_trans;
        r_s1_scale  <= r_scale;
        r_s1_xx     <= q_x * q_x;
        r_s1_yy     <= q_y * q_y;
        r_s1_zz     <= q_z * q_z;
        r_s1_xy     <= q_x * q_y;
        r_s1_xz     <= q_x * q_z;
        r_s1_yz     <= q_y * q_z;
        r_s1_wx     <= q_w * q_x;
        r_s1_wy     <= q_w * q_y;
        r_s1_wz     <= q_w * q_z;
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation matrix entries in Q6.28.
    // ------------------------------------------------------------------
    logic                                r_s2_vld;
    logic                                r_s2_hit;
    logic signed [COORD_W-1:0]           r_s2_pos [3];
    logic signed [mvat_pkg::TRANS_W-1:0] r_s2_trans [3];
    logic [mvat_pkg::SCALE_W-1:0]        r_s2_scale;
    logic signed [ROT_W-1:0]             r_s2_rot [3][3];

    always_ff @(posedge i_clk) begin
        r_s2_pos       <= r_s1_pos;
        r_s2_hit       <= r_s1_hit;
        r_s2_trans     <= r_s1_trans;
        r_s2_scale     <= r_s1_scale;
        r_s2_rot[0][0] <= ROT_ONE - ((ROT_W'(r_s1_yy) + ROT_W'(r_s1_zz)) <<< 1);
        r_s2_rot[0][1] <= (ROT_W'(r_s1_xy) - ROT_W'(r_s1_wz)) <<< 1;
        r_s2_rot[0][2] <= (ROT_W'(r_s1_xz) + ROT_W'(r_s1_wy)) <<< 1;
        r_s2_rot[1][0] <= (ROT_W'(r_s1_xy) + ROT_W'(r_s1_wz)) <<< 1;
        r_s2_rot[1][1] <= ROT_ONE - ((ROT_W'(r_s1_xx) + ROT_W'(r_s1_zz)) <<< 1);
        r_s2_rot[1][2] <= (ROT_W'(r_s1_yz) - ROT_W'(r_s1_wx)) <<< 1;
        r_s2_rot[2][0] <= (ROT_W'(r_s1_xz) - ROT_W'(r_s1_wy)) <<< 1;
        r_s2_rot[2][1] <= (ROT_W'(r_s1_yz) + ROT_W'(r_s1_wx)) <<< 1;
        r_s2_rot[2][2] <= ROT_ONE - ((ROT_W'(r_s1_xx) + ROT_W'(r_s1_yy)) <<< 1);
    end

    // ------------------------------------------------------------------
    // Stage 3: each matrix entry times the scale, exact.
    // ------------------------------------------------------------------
    logic                                r_s3_vld;
    logic                                r_s3_hit;
    logic signed [COORD_W-1:0]           r_s3_pos [3];
    logic signed [mvat_pkg::TRANS_W-1:0] r_s3_trans [3];
    logic signed [RS_W-1:0]              r_s3_rs [3][3];
    logic signed [mvat_pkg::SCALE_W:0]   scale_sx;
    logic signed [RS_W:0]                rs_full [3][3];

    assign scale_sx = signed'({1'b0, r_s2_scale});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rs_full[i][j] = r_s2_rot[i][j] * scale_sx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_pos   <= r_s2_pos;
        r_s3_hit   <= r_s2_hit;
        r_s3_trans <= r_s2_trans;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s3_rs[i][j] <= rs_full[i][j][RS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scaled entries times the coordinates, as two partial
    // products per entry (low half unsigned, high half signed).
    // ------------------------------------------------------------------
    logic                                r_s4_vld;
    logic                                r_s4_hit;
    logic signed [COORD_W-1:0]           r_s4_pos [3];
    logic signed [mvat_pkg::TRANS_W-1:0] r_s4_trans [3];
    logic signed [PL_W-1:0]              r_s4_pl [3][3];
    logic signed [PH_W-1:0]              r_s4_ph [3][3];

    always_ff @(posedge i_clk) begin
        r_s4_pos   <= r_s3_pos;
        r_s4_hit   <= r_s3_hit;
        r_s4_trans <= r_s3_trans;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s4_pl[i][j] <= signed'({1'b0, r_s3_rs[i][j][RS_LO-1:0]}) * r_s3_pos[j];
                r_s4_ph[i][j] <= signed'(r_s3_rs[i][j][RS_W-1:RS_LO]) * r_s3_pos[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: join the partial products into full terms (60 fraction bits).
    // ------------------------------------------------------------------
    logic                                r_s5_vld;
    logic                                r_s5_hit;
    logic signed [COORD_W-1:0]           r_s5_pos [3];
    logic signed [mvat_pkg::TRANS_W-1:0] r_s5_trans [3];
    logic signed [ACC_W-1:0]             r_s5_term [3][3];

    always_ff @(posedge i_clk) begin
        r_s5_pos   <= r_s4_pos;
        r_s5_hit   <= r_s4_hit;
        r_s5_trans <= r_s4_trans;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s5_term[i][j] <= (ACC_W'(r_s4_ph[i][j]) <<< RS_LO) + ACC_W'(r_s4_pl[i][j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: first half of the row sums; the translation and the
    // rounding half join the third term.
    // ------------------------------------------------------------------
    logic                                r_s6_vld;
    logic                                r_s6_hit;
    logic signed [COORD_W-1:0]           r_s6_pos [3];
    logic signed [ACC_W-1:0]             r_s6_sum_a [3];
    logic signed [ACC_W-1:0]             r_s6_sum_b [3];

    always_ff @(posedge i_clk) begin
        r_s6_pos <= r_s5_pos;
        r_s6_hit <= r_s5_hit;
        for (int i = 0; i < 3; i++) begin
            r_s6_sum_a[i] <= r_s5_term[i][0] + r_s5_term[i][1];
            r_s6_sum_b[i] <= r_s5_term[i][2] + (ACC_W'(r_s5_trans[i]) <<< FRAC_SH) + RND_HALF;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: complete row sums, already biased for round half up.
    // ------------------------------------------------------------------
    logic                                r_s7_vld;
    logic                                r_s7_hit;
    logic signed [COORD_W-1:0]           r_s7_pos [3];
    logic signed [ACC_W-1:0]             r_s7_acc [3];

    always_ff @(posedge i_clk) begin
        r_s7_pos <= r_s6_pos;
        r_s7_hit <= r_s6_hit;
        for (int i = 0; i < 3; i++) begin
            r_s7_acc[i] <= r_s6_sum_a[i] + r_s6_sum_b[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: drop the fraction bits (floor), saturate, and register the
    // result, or the unchanged vertex when it misses the mask. A coordinate
    // overflows when the bits above its sign bit are not all copies of it.
    // ------------------------------------------------------------------
    logic [RND_W-1:0]          rnd [3];
    logic signed [COORD_W-1:0] sat [3];
    logic [2:0]                ovf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = r_s7_acc[i][ACC_W-1:FRAC_SH];
            ovf[i] = !((&rnd[i][RND_W-1:COORD_W-1]) || !(|rnd[i][RND_W-1:COORD_W-1]));
            if (!ovf[i]) begin
                sat[i] = rnd[i][COORD_W-1:0];
            end else if (rnd[i][RND_W-1]) begin
                sat[i] = COORD_MIN;
            end else begin
                sat[i] = COORD_MAX;
            end
        end
    end

    logic               r_done;
    mvat_pkg::t_vtx_out r_res;
    mvat_pkg::t_vtx_out n_res;

    always_comb begin
        if (r_s7_hit) begin
            n_res.out_x   = sat[0];
            n_res.out_y   = sat[1];
            n_res.out_z   = sat[2];
            n_res.moved   = 1'b1;
            n_res.clipped = |ovf;
        end else begin
            n_res.out_x   = r_s7_pos[0];
            n_res.out_y   = r_s7_pos[1];
            n_res.out_z   = r_s7_pos[2];
            n_res.moved   = 1'b0;
            n_res.clipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Valid bits travel beside the data; only they are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_done   <= r_s7_vld;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
